@@ rtl/swhc_pkg.sv @@
// shared types and constants for the sliding window hit counter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package swhc_pkg;

	localparam int WINDOW    = 300;
	localparam int TIME_W    = 32;
	localparam int COUNT_W   = 16;
	localparam int TOTAL_W   = 25;
	localparam int SLOT_W    = $clog2(WINDOW);
	localparam int MEM_W     = TIME_W + COUNT_W;
	// remainder reduction: bits of the time word consumed per cycle
	localparam int MOD_STEP  = 4;
	localparam int MOD_CYC   = TIME_W / MOD_STEP;
	localparam int MODCNT_W  = $clog2(MOD_CYC);

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef enum logic {
		OP_HIT   = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct packed {
		op_t               opcode;
		logic [TIME_W-1:0] time_seconds;
		logic [SLOT_W-1:0] slot;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MOD,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_HIT_RD,
		B_HIT_WR,
		B_QRY,
		B_QDRAIN
	} back_state_t;

endpackage

@@ rtl/swhc_front.sv @@
// front end: takes commands and works out the bucket index of a hit
// depends on swhc_pkg; feeds swhc_queue
`timescale 1ns / 1ps

module swhc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        opcode,
	input  logic [swhc_pkg::TIME_W-1:0] time_seconds,
	input  swhc_pkg::queue_stat_t       q_stat,
	output logic                        idle,
	output logic                        push,
	output swhc_pkg::cmd_t              push_cmd
);
	import swhc_pkg::*;

	front_state_t              state_q, state_d;
	op_t                       op_q;
	logic [TIME_W-1:0]         time_q;
	logic [TIME_W-1:0]         shift_q;
	logic [SLOT_W-1:0]         rem_q;
	logic [SLOT_W-1:0]         rem_d;
	logic [MODCNT_W-1:0]       cnt_q;
	logic                      accept;

	assign idle   = (state_q == F_IDLE);
	assign accept = idle && start;

	// restoring reduction of the time word modulo the window, MOD_STEP bits a cycle
	always_comb begin
		logic [SLOT_W:0] r;
		r = {1'b0, rem_q};
		for (int i = 0; i < MOD_STEP; i++) begin
			r = {r[SLOT_W-1:0], shift_q[TIME_W-1-i]};
			if (r >= (SLOT_W+1)'(WINDOW))
				r = r - (SLOT_W+1)'(WINDOW);
		end
		rem_d = r[SLOT_W-1:0];
	end

	always_comb begin
		state_d  = state_q;
		push     = 1'b0;
		push_cmd = '{opcode: op_q, time_seconds: time_q, slot: rem_q};
		case (state_q)
			F_IDLE: begin
				if (start)
					state_d = (op_t'(opcode) == OP_HIT) ? F_MOD : F_PUSH;
			end
			F_MOD: begin
				if (cnt_q == MODCNT_W'(MOD_CYC - 1))
					state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!q_stat.full) begin
					push    = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= F_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(opcode);
			time_q  <= time_seconds;
			shift_q <= time_seconds;
			rem_q   <= '0;
			cnt_q   <= '0;
		end else if (state_q == F_MOD) begin
			shift_q <= shift_q << MOD_STEP;
			rem_q   <= rem_d;
			cnt_q   <= cnt_q + 1'b1;
		end
	end

endmodule

@@ rtl/swhc_queue.sv @@
// two-entry command queue between front and back
// depends on swhc_pkg
`timescale 1ns / 1ps

module swhc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  swhc_pkg::cmd_t        push_cmd,
	input  logic                  pop,
	output swhc_pkg::cmd_t        pop_cmd,
	output swhc_pkg::queue_stat_t q_stat
);
	import swhc_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign pop_cmd      = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == 2'd2);
	assign q_stat.empty = (count_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

@@ rtl/swhc_back.sv @@
// back end: bucket memory, hit update and window sweep for queries
// depends on swhc_pkg; takes commands from swhc_queue
`timescale 1ns / 1ps

module swhc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  swhc_pkg::queue_stat_t        q_stat,
	input  swhc_pkg::cmd_t               pop_cmd,
	output logic                         pop,
	output swhc_pkg::back_stat_t         b_stat,
	output logic                         done,
	output logic [swhc_pkg::TOTAL_W-1:0] hit_total
);
	import swhc_pkg::*;

	logic [MEM_W-1:0]   mem [WINDOW];
	logic [MEM_W-1:0]   rd_data_q;
	logic               rd_en;
	logic [SLOT_W-1:0]  rd_addr;
	logic               wr_en;
	logic [SLOT_W-1:0]  wr_addr;
	logic [MEM_W-1:0]   wr_data;

	back_state_t        state_q, state_d;
	logic [SLOT_W-1:0]  idx_q;
	logic [TIME_W-1:0]  time_q;
	logic [TOTAL_W-1:0] sum_q;
	logic               rd_vld_s1;
	logic               add_vld_s2;
	logic [COUNT_W-1:0] add_s2;

	logic [TIME_W-1:0]  rd_stamp;
	logic [COUNT_W-1:0] rd_count;
	logic [TIME_W-1:0]  diff;
	logic               in_window;
	logic [TOTAL_W:0]   sum_ext;

	assign rd_stamp  = rd_data_q[MEM_W-1:COUNT_W];
	assign rd_count  = rd_data_q[COUNT_W-1:0];
	assign diff      = time_q - rd_stamp;
	assign in_window = diff[TIME_W-1] || (diff < TIME_W'(WINDOW));
	assign sum_ext   = {1'b0, sum_q} + {{(TOTAL_W+1-COUNT_W){1'b0}}, add_s2};

	assign b_stat.clearing = (state_q == B_CLEAR);
	assign hit_total       = sum_q;

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		done    = 1'b0;
		rd_en   = 1'b0;
		rd_addr = idx_q;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = '0;
		case (state_q)
			B_CLEAR: begin
				wr_en = 1'b1;
				if (idx_q == SLOT_W'(WINDOW - 1))
					state_d = B_IDLE;
			end
			B_IDLE: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					state_d = (pop_cmd.opcode == OP_HIT) ? B_HIT_RD : B_QRY;
				end
			end
			B_HIT_RD: begin
				rd_en   = 1'b1;
				state_d = B_HIT_WR;
			end
			B_HIT_WR: begin
				// same second bumps the count, a newer second restarts the bucket
				if (rd_stamp == time_q) begin
					wr_en   = (rd_count != COUNT_MAX);
					wr_data = {rd_stamp, rd_count + 1'b1};
				end else if (time_q > rd_stamp) begin
					wr_en   = 1'b1;
					wr_data = {time_q, COUNT_W'(1)};
				end
				state_d = B_IDLE;
			end
			B_QRY: begin
				rd_en = 1'b1;
				if (idx_q == SLOT_W'(WINDOW - 1))
					state_d = B_QDRAIN;
			end
			B_QDRAIN: begin
				if (!rd_vld_s1 && !add_vld_s2) begin
					done    = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_CLEAR;
			idx_q      <= '0;
			rd_vld_s1  <= 1'b0;
			add_vld_s2 <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_vld_s1  <= (state_q == B_QRY);
			add_vld_s2 <= rd_vld_s1;
			if (state_q == B_CLEAR || state_q == B_QRY) begin
				if (idx_q == SLOT_W'(WINDOW - 1))
					idx_q <= '0;
				else
					idx_q <= idx_q + 1'b1;
			end else if (pop) begin
				idx_q <= (pop_cmd.opcode == OP_HIT) ? pop_cmd.slot : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			time_q <= pop_cmd.time_seconds;
			sum_q  <= '0;
		end else if (add_vld_s2) begin
			sum_q <= sum_ext[TOTAL_W] ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];
		end
		add_s2 <= (rd_vld_s1 && in_window) ? rd_count : '0;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

endmodule

@@ rtl/sliding_window_hit_counter.sv @@
// top level of the sliding window hit counter
// depends on swhc_pkg, swhc_front, swhc_queue, swhc_back
//
//   channel   ports                       transfer when
//   command   start, opcode, time_seconds start && !busy
//   result    done, hit_total             done (one cycle, no back-pressure)
//
// after reset the bucket memory is cleared, one bucket a cycle, through all WINDOW buckets;
// busy stays high meanwhile
// a hit first runs the index reduction in the front, 4 bits a cycle,
// then a read-modify-write of one bucket in the back
// a query sweeps every bucket on the single read port, one read per bucket,
// then waits for the sum pipeline to drain before done
// a two-entry queue lets the front take new commands while the back sweeps
`timescale 1ns / 1ps

module sliding_window_hit_counter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         opcode,
	input  logic [swhc_pkg::TIME_W-1:0]  time_seconds,
	output logic                         done,
	output logic [swhc_pkg::TOTAL_W-1:0] hit_total
);
	import swhc_pkg::*;

	logic        front_idle;
	logic        push;
	logic        pop;
	cmd_t        push_cmd;
	cmd_t        pop_cmd;
	queue_stat_t q_stat;
	back_stat_t  b_stat;
	logic        front_start;

	assign busy        = !front_idle || b_stat.clearing;
	assign front_start = start && !b_stat.clearing;

	swhc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (front_start),
		.opcode       (opcode),
		.time_seconds (time_seconds),
		.q_stat       (q_stat),
		.idle         (front_idle),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	swhc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.q_stat   (q_stat)
	);

	swhc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_cmd   (pop_cmd),
		.pop       (pop),
		.b_stat    (b_stat),
		.done      (done),
		.hit_total (hit_total)
	);

endmodule
